>>> hw/rtl/mmtl_pkg.sv
package mmtl_pkg;

  // Sizes of the stores
  localparam int PROGRAM_ROM_BYTES = 16384;
  localparam int TEXT_COLUMNS      = 32;
  localparam int VISIBLE_LINES     = 200;
  localparam int CHAR_ROM_BYTES    = 2048;
  localparam int RAM_BYTES         = 1024;

  localparam int PROG_AW = $clog2(PROGRAM_ROM_BYTES);
  localparam int CHAR_AW = $clog2(CHAR_ROM_BYTES);
  localparam int RAM_AW  = $clog2(RAM_BYTES);

  // Clear sweep covers the larger ROM
  localparam int CLR_DEPTH = (PROGRAM_ROM_BYTES > CHAR_ROM_BYTES) ?
                             PROGRAM_ROM_BYTES : CHAR_ROM_BYTES;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);

  // Bus map
  localparam logic [15:0] WORK_BASE    = 16'h5000;
  localparam logic [15:0] WORK_END     = 16'h5400;
  localparam logic [15:0] DISP_BASE    = 16'h6000;
  localparam logic [15:0] DISP_END     = 16'h6400;
  localparam logic [15:0] KEY_ADDR     = 16'h7001;
  localparam logic [15:0] STROBE_ADDR  = 16'h7002;
  localparam logic [15:0] SPEAKER_ADDR = 16'h7004;
  localparam logic [7:0]  OPEN_BUS     = 8'hFF;

  // Command codes
  localparam logic [2:0] CMD_READ      = 3'd0;
  localparam logic [2:0] CMD_WRITE     = 3'd1;
  localparam logic [2:0] CMD_KEY       = 3'd2;
  localparam logic [2:0] CMD_DRAW      = 3'd3;
  localparam logic [2:0] CMD_LOAD_PROG = 3'd4;
  localparam logic [2:0] CMD_LOAD_CHAR = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  line;
  } mmtl_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] pixels;
    logic [4:0] column;
    logic       last;
    logic       strobe_valid;
    logic [7:0] strobe_data;
    logic       speaker_valid;
    logic       speaker_level;
  } mmtl_out_t;

endpackage

>>> hw/rtl/memory_map_and_text_line_render_top.sv
// Memory map and character display of a small 8-bit machine. After reset the block
// sweeps its ROM and RAM stores once, one address a cycle over 16384 addresses (the larger
// of the program ROM and character ROM sizes), with busy high; no item is taken then.
// A bus read or write is taken in an accept cycle, where the memory is read or written,
// and its result is shown in the next cycle. Key data, ROM loads, off-screen draws and
// unused codes give no result. In a visible line draw, each column's display code and
// then its character pattern come from two synchronous memories in series, and the 32
// pixel bytes come out one per cycle. The receiver cannot stall: each result is shown
// for exactly one cycle with out_valid high and must be taken then.
module memory_map_and_text_line_render_top
  import mmtl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mmtl_in_t  in_item,
  output logic      out_valid,
  output mmtl_out_t out_item
);

  // Controller states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RESP  = 2'd2;
  localparam logic [1:0] ST_DRAW  = 2'd3;

  // Read source of a bus read
  localparam logic [2:0] RS_PROG = 3'd0;
  localparam logic [2:0] RS_WORK = 3'd1;
  localparam logic [2:0] RS_DISP = 3'd2;
  localparam logic [2:0] RS_KEY  = 3'd3;
  localparam logic [2:0] RS_OPEN = 3'd4;

  logic [7:0] prog_mem [PROGRAM_ROM_BYTES];
  logic [7:0] char_mem [CHAR_ROM_BYTES];
  logic [7:0] work_mem [RAM_BYTES];
  logic [7:0] disp_mem [RAM_BYTES];

  logic [1:0]        state_r, state_nxt;
  logic [CLR_AW-1:0] clr_r;
  logic [7:0]        key_r;
  logic              speaker_r;
  logic [2:0]        rsel_r;
  logic              is_write_r;
  logic              strobe_r;
  logic              spk_upd_r;
  logic [7:0]        wdata_r;
  logic [7:0]        line_r;
  logic [5:0]        iss_col_r;
  logic              p1_v_r, p2_v_r;
  logic [4:0]        p1_col_r, p2_col_r;
  logic [7:0]        prog_q_r, work_q_r, disp_q_r, char_q_r;

  logic acc;
  logic in_prog, in_work, in_disp, line_vis;
  logic clr_prog, clr_char, clr_ram;
  logic issue;
  logic [RAM_AW-1:0]  disp_raddr;
  logic [CHAR_AW-1:0] char_raddr;
  logic               draw_done;

  assign busy = (state_r != ST_IDLE);
  assign acc  = start && !busy;

  // Address decode of the incoming item
  assign in_prog  = {1'b0, in_item.addr} < 17'(PROGRAM_ROM_BYTES);
  assign in_work  = (in_item.addr >= WORK_BASE) && (in_item.addr < WORK_END);
  assign in_disp  = (in_item.addr >= DISP_BASE) && (in_item.addr < DISP_END);
  assign line_vis = {1'b0, in_item.line} < 9'(VISIBLE_LINES);

  // Clear sweep enables
  assign clr_prog = (state_r == ST_CLEAR) && (32'(clr_r) < PROGRAM_ROM_BYTES);
  assign clr_char = (state_r == ST_CLEAR) && (32'(clr_r) < CHAR_ROM_BYTES);
  assign clr_ram  = (state_r == ST_CLEAR) && (32'(clr_r) < RAM_BYTES);

  // Draw issue: one display code read a cycle
  assign issue      = (state_r == ST_DRAW) && !iss_col_r[5];
  assign disp_raddr = issue ? {line_r[7:3], iss_col_r[4:0]} : in_item.addr[RAM_AW-1:0];
  assign char_raddr = {disp_q_r, line_r[2:0]};
  assign draw_done  = p2_v_r && (p2_col_r == 5'(TEXT_COLUMNS - 1));

  // Program ROM
  always_ff @(posedge clk) begin
    if (clr_prog) begin
      prog_mem[clr_r[PROG_AW-1:0]] <= OPEN_BUS;
    end else if (acc && in_item.cmd == CMD_LOAD_PROG && in_prog) begin
      prog_mem[in_item.addr[PROG_AW-1:0]] <= in_item.wdata;
    end
    if (acc && in_prog) begin
      prog_q_r <= prog_mem[in_item.addr[PROG_AW-1:0]];
    end
  end

  // Character ROM
  always_ff @(posedge clk) begin
    if (clr_char) begin
      char_mem[clr_r[CHAR_AW-1:0]] <= 8'h00;
    end else if (acc && in_item.cmd == CMD_LOAD_CHAR &&
                 in_item.addr < 16'(CHAR_ROM_BYTES)) begin
      char_mem[in_item.addr[CHAR_AW-1:0]] <= in_item.wdata;
    end
    if (p1_v_r) begin
      char_q_r <= char_mem[char_raddr];
    end
  end

  // Work RAM
  always_ff @(posedge clk) begin
    if (clr_ram) begin
      work_mem[clr_r[RAM_AW-1:0]] <= 8'h00;
    end else if (acc && in_item.cmd == CMD_WRITE && in_work) begin
      work_mem[in_item.addr[RAM_AW-1:0]] <= in_item.wdata;
    end
    if (acc) begin
      work_q_r <= work_mem[in_item.addr[RAM_AW-1:0]];
    end
  end

  // Display RAM, shared read port for bus reads and draws
  always_ff @(posedge clk) begin
    if (clr_ram) begin
      disp_mem[clr_r[RAM_AW-1:0]] <= 8'h00;
    end else if (acc && in_item.cmd == CMD_WRITE && in_disp) begin
      disp_mem[in_item.addr[RAM_AW-1:0]] <= in_item.wdata;
    end
    if (acc || issue) begin
      disp_q_r <= disp_mem[disp_raddr];
    end
  end

  // Controller
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == CLR_AW'(CLR_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (acc) begin
          if (in_item.cmd == CMD_READ || in_item.cmd == CMD_WRITE) begin
            state_nxt = ST_RESP;
          end else if (in_item.cmd == CMD_DRAW && line_vis) begin
            state_nxt = ST_DRAW;
          end
        end
      end
      ST_RESP: state_nxt = ST_IDLE;
      ST_DRAW: if (draw_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      key_r     <= 8'h00;
      speaker_r <= 1'b0;
      iss_col_r <= '0;
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (acc && in_item.cmd == CMD_KEY) key_r <= in_item.wdata;
      if (acc && in_item.cmd == CMD_WRITE && in_item.addr == SPEAKER_ADDR) begin
        speaker_r <= in_item.wdata[0];
      end
      if (acc) begin
        iss_col_r <= '0;
      end else if (issue) begin
        iss_col_r <= iss_col_r + 1'b1;
      end
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
    end
  end

  // Captured item fields and draw column tags
  always_ff @(posedge clk) begin
    if (acc) begin
      is_write_r <= (in_item.cmd == CMD_WRITE);
      strobe_r   <= (in_item.addr == STROBE_ADDR);
      spk_upd_r  <= (in_item.addr == SPEAKER_ADDR);
      wdata_r    <= in_item.wdata;
      line_r     <= in_item.line;
      if (in_prog)                     rsel_r <= RS_PROG;
      else if (in_work)                rsel_r <= RS_WORK;
      else if (in_disp)                rsel_r <= RS_DISP;
      else if (in_item.addr == KEY_ADDR) rsel_r <= RS_KEY;
      else                             rsel_r <= RS_OPEN;
    end
    p1_col_r <= iss_col_r[4:0];
    p2_col_r <= p1_col_r;
  end

  // Result assembly
  assign out_valid = (state_r == ST_RESP) || ((state_r == ST_DRAW) && p2_v_r);

  always_comb begin
    out_item               = '0;
    out_item.speaker_level = speaker_r;
    if (state_r == ST_RESP) begin
      out_item.last = 1'b1;
      if (is_write_r) begin
        out_item.strobe_valid  = strobe_r;
        out_item.strobe_data   = strobe_r ? wdata_r : 8'h00;
        out_item.speaker_valid = spk_upd_r;
      end else begin
        unique case (rsel_r)
          RS_PROG: out_item.read_data = prog_q_r;
          RS_WORK: out_item.read_data = work_q_r;
          RS_DISP: out_item.read_data = disp_q_r;
          RS_KEY:  out_item.read_data = key_r;
          default: out_item.read_data = OPEN_BUS;
        endcase
      end
    end else if (state_r == ST_DRAW && p2_v_r) begin
      out_item.pixels = char_q_r;
      out_item.column = p2_col_r;
      out_item.last   = draw_done;
    end
  end

`ifndef SYNTHESIS
  // A bus read or write gives its single result in the next cycle
  a_rw_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_item.cmd == CMD_READ || in_item.cmd == CMD_WRITE))
      |=> (out_valid && out_item.last))
    else $error("bus access result missing");

  // Results only appear while the block is busy
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result while idle");

  // Draw columns come out in order, one per cycle
  a_col_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && state_r == ST_DRAW && out_item.column != 5'd0)
      |-> ($past(out_valid) && $past(out_item.column) == out_item.column - 5'd1))
    else $error("draw column out of order");
`endif

endmodule

>>> dv/mmtl_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own image of the memory map and
// compares every result with the oldest outstanding prediction.
module mmtl_checker
  import mmtl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  mmtl_in_t  in_item,
  input  logic      out_valid,
  input  mmtl_out_t out_item,
  output int        n_fail,
  output int        n_pending,
  output int        n_checked
);

  localparam logic [15:0] PROG_SPACE_END = 16'h4000;

  // Shadow copy of every store in the block
  logic [7:0] prog_img [PROGRAM_ROM_BYTES];
  logic [7:0] char_img [CHAR_ROM_BYTES];
  logic [7:0] work_img [RAM_BYTES];
  logic [7:0] disp_img [RAM_BYTES];
  logic [7:0] key_img;
  logic       spk_img;

  mmtl_out_t  due_results [$];
  mmtl_out_t  want;
  int         fail_total = 0;
  int         checked_total = 0;

  // Byte seen by a CPU read at address a
  function automatic logic [7:0] bus_peek(logic [15:0] a);
    if (a < PROG_SPACE_END)
      return (a < PROGRAM_ROM_BYTES) ? prog_img[a] : OPEN_BUS;
    if (a >= WORK_BASE && a < WORK_END)
      return work_img[a - WORK_BASE];
    if (a >= DISP_BASE && a < DISP_END)
      return disp_img[a - DISP_BASE];
    if (a == KEY_ADDR)
      return key_img;
    return OPEN_BUS;
  endfunction

  // Update the image for one command and queue the results it causes
  task automatic apply_command(mmtl_in_t it);
    mmtl_out_t r;
    int        ptr;
    r = '0;
    case (it.cmd)
      CMD_READ: begin
        r.read_data     = bus_peek(it.addr);
        r.last          = 1'b1;
        r.speaker_level = spk_img;
        due_results.push_back(r);
      end
      CMD_WRITE: begin
        if (it.addr >= WORK_BASE && it.addr < WORK_END) begin
          work_img[it.addr - WORK_BASE] = it.wdata;
        end else if (it.addr >= DISP_BASE && it.addr < DISP_END) begin
          disp_img[it.addr - DISP_BASE] = it.wdata;
        end else if (it.addr == STROBE_ADDR) begin
          r.strobe_valid = 1'b1;
          r.strobe_data  = it.wdata;
        end else if (it.addr == SPEAKER_ADDR) begin
          spk_img         = it.wdata[0];
          r.speaker_valid = 1'b1;
        end
        r.last          = 1'b1;
        r.speaker_level = spk_img;
        due_results.push_back(r);
      end
      CMD_KEY: begin
        key_img = it.wdata;
      end
      CMD_DRAW: begin
        // one pixel byte per text column; off-screen lines draw nothing
        if (it.line < VISIBLE_LINES) begin
          for (int i = 0; i < TEXT_COLUMNS; i++) begin
            ptr             = (TEXT_COLUMNS * int'(it.line >> 3) + i) % RAM_BYTES;
            r               = '0;
            r.pixels        = char_img[{disp_img[ptr], it.line[2:0]}];
            r.column        = 5'(i);
            r.last          = (i == TEXT_COLUMNS - 1);
            r.speaker_level = spk_img;
            due_results.push_back(r);
          end
        end
      end
      CMD_LOAD_PROG: begin
        if (it.addr < PROGRAM_ROM_BYTES)
          prog_img[it.addr] = it.wdata;
      end
      CMD_LOAD_CHAR: begin
        if (it.addr < CHAR_ROM_BYTES)
          char_img[it.addr] = it.wdata;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_total++;
    end
  endtask

  // Results first: anything coming out now belongs to older items
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PROGRAM_ROM_BYTES; i++) prog_img[i] = 8'hFF;
      for (int i = 0; i < CHAR_ROM_BYTES; i++) char_img[i] = 8'h00;
      for (int i = 0; i < RAM_BYTES; i++) begin
        work_img[i] = 8'h00;
        disp_img[i] = 8'h00;
      end
      key_img = 8'h00;
      spk_img = 1'b0;
      due_results.delete();
    end else begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("result with nothing outstanding: %h", out_item);
          fail_total++;
        end else begin
          want = due_results.pop_front();
          check_field("read_data", want.read_data, out_item.read_data);
          check_field("pixels", want.pixels, out_item.pixels);
          check_field("column", want.column, out_item.column);
          check_field("last", want.last, out_item.last);
          check_field("strobe_valid", want.strobe_valid, out_item.strobe_valid);
          check_field("strobe_data", want.strobe_data, out_item.strobe_data);
          check_field("speaker_valid", want.speaker_valid, out_item.speaker_valid);
          check_field("speaker_level", want.speaker_level, out_item.speaker_level);
          checked_total++;
        end
      end
      if (start && !busy)
        apply_command(in_item);
    end
    n_fail    <= fail_total;
    n_pending <= due_results.size();
    n_checked <= checked_total;
  end

endmodule

>>> dv/memory_map_and_text_line_render_top_tb.sv
`timescale 1ns / 1ps

module memory_map_and_text_line_render_top_tb;
  import mmtl_pkg::*;

  localparam int TOTAL_ITEMS  = 430;
  // reset sweep plus every item as a draw after a long gap, many times over
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  mmtl_in_t  in_item;
  logic      out_valid;
  mmtl_out_t out_item;

  int n_fail;
  int n_pending;
  int n_checked;
  int cycles = 0;
  int n_sent = 0;
  int n_by_cmd [8];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  memory_map_and_text_line_render_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  mmtl_checker i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .n_fail   (n_fail),
    .n_pending(n_pending),
    .n_checked(n_checked)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("memory_map_and_text_line_render_top_tb failed");
      $finish;
    end
  end

  // Present one command and hold it until the block takes it
  task automatic send_item(logic [2:0] cmd, logic [15:0] addr, logic [7:0] wdata,
                           logic [7:0] line);
    mmtl_in_t it;
    it.cmd   = cmd;
    it.addr  = addr;
    it.wdata = wdata;
    it.line  = line;
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_by_cmd[cmd]++;
    n_sent++;
  endtask

  // Random pause between items: mostly none or short, now and then long
  task automatic idle_gap(bit quiet);
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!quiet) begin
      if (r >= 90)
        n = $urandom_range(8, 40);
      else if (r >= 50)
        n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Bus address spread over every region, its edges and open space
  function automatic logic [15:0] pick_addr();
    logic [15:0] edges [12] = '{16'h3FFF, 16'h4000, 16'h4FFF, WORK_END, 16'h5FFF,
                                DISP_END, 16'h6FFF, 16'h7000, KEY_ADDR, STROBE_ADDR,
                                SPEAKER_ADDR, 16'hFFFF};
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'($urandom_range(0, 16'h3FFF));
    if (r < 40) return WORK_BASE + 16'($urandom_range(0, RAM_BYTES - 1));
    if (r < 60) return DISP_BASE + 16'($urandom_range(0, RAM_BYTES - 1));
    if (r < 75) return 16'h7000 + 16'($urandom_range(0, 7));
    if (r < 85) return edges[$urandom_range(0, 11)];
    return 16'($urandom);
  endfunction

  // One stand-alone command of any kind, ignored ones included
  task automatic random_command(bit quiet);
    int          r;
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  line;
    r    = $urandom_range(0, 99);
    addr = pick_addr();
    line = 8'($urandom);
    if (r < 20) begin
      cmd = CMD_READ;
    end else if (r < 45) begin
      cmd = CMD_WRITE;
    end else if (r < 52) begin
      cmd = CMD_KEY;
    end else if (r < 62) begin
      cmd  = CMD_DRAW;
      line = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(VISIBLE_LINES, 255))
                                          : 8'($urandom_range(0, VISIBLE_LINES - 1));
    end else if (r < 75) begin
      cmd  = CMD_LOAD_PROG;
      addr = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(0, PROGRAM_ROM_BYTES - 1));
    end else if (r < 96) begin
      cmd  = CMD_LOAD_CHAR;
      addr = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(0, CHAR_ROM_BYTES - 1));
    end else begin
      cmd = 3'($urandom_range(6, 7));
    end
    send_item(cmd, addr, 8'($urandom), line);
    idle_gap(quiet);
  endtask

  // Load a glyph, place it on a text row, draw a line of that row, read back
  task automatic draw_scene(bit quiet);
    int glyph;
    int row;
    int nw;
    glyph = $urandom_range(0, 255);
    row   = $urandom_range(0, VISIBLE_LINES / 8 - 1);
    for (int k = 0; k < 8; k++) begin
      send_item(CMD_LOAD_CHAR, 16'(glyph * 8 + k), 8'($urandom), 8'($urandom));
      idle_gap(quiet);
    end
    nw = $urandom_range(1, 6);
    for (int k = 0; k < nw; k++) begin
      send_item(CMD_WRITE, DISP_BASE + 16'(row * TEXT_COLUMNS + $urandom_range(0, 31)),
                $urandom_range(0, 1) ? 8'(glyph) : 8'($urandom), 8'($urandom));
      idle_gap(quiet);
    end
    send_item(CMD_DRAW, 16'($urandom), 8'($urandom), 8'(row * 8 + $urandom_range(0, 7)));
    idle_gap(quiet);
    send_item(CMD_READ, DISP_BASE + 16'(row * TEXT_COLUMNS + $urandom_range(0, 31)),
              8'($urandom), 8'($urandom));
    idle_gap(quiet);
  endtask

  initial begin
    int  phase;
    bit  quiet;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, region edges, ignored loads and writes,
    // strobe and speaker, visible and off-screen draws, unused commands
    send_item(CMD_READ, 16'h0000, 8'h00, 8'h00);
    send_item(CMD_LOAD_PROG, 16'h0000, 8'hA5, 8'h00);
    send_item(CMD_LOAD_PROG, 16'h3FFF, 8'h5A, 8'h00);
    send_item(CMD_LOAD_PROG, 16'h4000, 8'h77, 8'h00);
    send_item(CMD_READ, 16'h3FFF, 8'h00, 8'h00);
    send_item(CMD_LOAD_CHAR, 16'h0000, 8'h81, 8'h00);
    send_item(CMD_LOAD_CHAR, 16'h07FF, 8'hFF, 8'h00);
    send_item(CMD_LOAD_CHAR, 16'h0800, 8'h33, 8'h00);
    send_item(CMD_KEY, 16'h0000, 8'hFF, 8'h00);
    send_item(CMD_READ, KEY_ADDR, 8'h00, 8'h00);
    send_item(CMD_WRITE, 16'h53FF, 8'hEE, 8'h00);
    send_item(CMD_WRITE, DISP_BASE, 8'h00, 8'h00);
    send_item(CMD_WRITE, 16'h63FF, 8'hFF, 8'h00);
    send_item(CMD_WRITE, STROBE_ADDR, 8'h96, 8'h00);
    send_item(CMD_WRITE, SPEAKER_ADDR, 8'hFF, 8'h00);
    send_item(CMD_WRITE, 16'h0000, 8'h00, 8'h00);
    send_item(CMD_WRITE, 16'hFFFF, 8'h12, 8'hFF);
    send_item(CMD_READ, 16'h63FF, 8'h00, 8'h00);
    send_item(CMD_READ, 16'hFFFF, 8'h00, 8'h00);
    send_item(CMD_DRAW, 16'h0000, 8'h00, 8'd0);
    send_item(CMD_DRAW, 16'h0000, 8'h00, 8'(VISIBLE_LINES - 1));
    send_item(CMD_DRAW, 16'h0000, 8'h00, 8'(VISIBLE_LINES));
    send_item(3'd6, 16'h6000, 8'h55, 8'h00);
    send_item(3'd7, 16'h7004, 8'hAA, 8'h00);
    send_item(CMD_WRITE, SPEAKER_ADDR, 8'hFE, 8'h00);

    // Random: glyph and draw sequences mixed with loose commands;
    // every third stretch runs back to back
    phase = 0;
    while (n_sent < TOTAL_ITEMS) begin
      quiet = ((phase / 40) % 3 == 2);
      if ($urandom_range(0, 99) < 15)
        draw_scene(quiet);
      else
        random_command(quiet);
      phase++;
    end
    start <= 1'b0;

    // Drain, then allow a full draw's latency for stray results
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Commands taken: %0d read, %0d write, %0d key, %0d draw, %0d program load,",
             n_by_cmd[CMD_READ], n_by_cmd[CMD_WRITE], n_by_cmd[CMD_KEY],
             n_by_cmd[CMD_DRAW], n_by_cmd[CMD_LOAD_PROG]);
    $display("  %0d glyph load, %0d unused codes; %0d results compared, %0d mismatches",
             n_by_cmd[CMD_LOAD_CHAR], n_by_cmd[6] + n_by_cmd[7], n_checked, n_fail);
    if (n_fail == 0)
      $display("memory_map_and_text_line_render_top_tb passed");
    else
      $display("memory_map_and_text_line_render_top_tb failed");
    $finish;
  end

endmodule

>>> memory_map_and_text_line_render_top.f
hw/rtl/mmtl_pkg.sv
hw/rtl/memory_map_and_text_line_render_top.sv
dv/mmtl_checker.sv
dv/memory_map_and_text_line_render_top_tb.sv
